@@ hdl/bpl_pkg.sv @@
// Package for the bounded positional list: field widths, request kinds,
// result status codes and the command/status types between controller and datapath.
// Used by every module of the block; depends on nothing.
package bpl_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam int DEFAULT_WORD_WIDTH  = 32;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int BYTES_W  = 3;
   localparam int LEN_W    = 7;
   localparam int CAP_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INS_FIRST = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_LAST  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXT_FIRST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXT_LAST  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EXT_AT    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ_AT   = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] RSP_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_RANGE = 2'd3;

   // Configuration register byte offsets.
   localparam logic [2:0] CSR_CAPACITY_ADDR = 3'd0;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_INS  = 2'd1,
      OP_EXT  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      logic capture;
      logic decide;
      logic step_up;
      logic step_down;
      logic place;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type plan_op;
      logic   walk_done;
   } stat_type;

endpackage

@@ hdl/bounded_positional_list.sv @@
// Bounded positional list: top level with stream ports, capacity register
// and the controller/datapath pair. Depends on bpl_pkg, bpl_ctrl and bpl_dpath.
// A request is captured and decoded; an insert moves entries up and places the word, an
// extract or read walks entries down, and a refused request goes straight to the result.
// One entry moves per cycle through the write port; one word at a time, held by result stalls.
// Reset clears the length to zero and capacity to 64; the element memory is not cleared.
module bounded_positional_list
   import bpl_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
   parameter int WORD_WIDTH  = DEFAULT_WORD_WIDTH,
   localparam int ReqDataW   = ((POS_W + WORD_WIDTH + BYTES_W + 7) / 8) * 8,
   localparam int RspDataW   = ((WORD_WIDTH + BYTES_W + LEN_W + 2 + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // position [6:0], element_value, element_bytes
   input  logic [ReqDataW-1:0] req_tdata,
   // kind [2:0]
   input  logic [KIND_W-1:0]   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // result_value, result_bytes, length, is_empty, is_full
   output logic [RspDataW-1:0] rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0] rsp_tuser,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [CAP_W-1:0] cap_ff;
   logic             cap_sel;

   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr[2] == CSR_CAPACITY_ADDR[2]);
   assign csr_prdata = cap_sel ? 32'(cap_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && cap_sel) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   cmd_type  cmd;
   stat_type stat;

   logic [WORD_WIDTH-1:0] res_value;
   logic [BYTES_W-1:0]    res_bytes;
   logic [LEN_W-1:0]      res_length;
   logic                  res_empty;
   logic                  res_full;

   bpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpl_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_tuser),
      .req_position      (req_tdata[POS_W-1:0]),
      .req_element_value (req_tdata[POS_W +: WORD_WIDTH]),
      .req_element_bytes (req_tdata[POS_W + WORD_WIDTH +: BYTES_W]),
      .capacity          (cap_ff),
      .rsp_status        (rsp_tuser),
      .rsp_result_value  (res_value),
      .rsp_result_bytes  (res_bytes),
      .rsp_length        (res_length),
      .rsp_is_empty      (res_empty),
      .rsp_is_full       (res_full)
   );

   assign rsp_tdata = RspDataW'({res_full, res_empty, res_length, res_bytes, res_value});

   // One word is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new word accepted while one is in flight");

   a_empty_matches_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res_empty == (res_length == '0)))
      else $error("empty flag disagrees with list length");

   a_full_status_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RSP_FULL |-> res_full)
      else $error("full status without full flag");

   a_no_payload_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RSP_OK |-> (res_value == '0 && res_bytes == '0))
      else $error("payload returned with an error status");

endmodule

@@ hdl/bpl_ctrl.sv @@
// Controller of the bounded positional list: sequences capture, decode,
// entry walk, placement and result hand-off, and owns the handshakes.
// Depends on bpl_pkg.
module bpl_ctrl
   import bpl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_UP     = 6'b000100,
      S_PLACE  = 6'b001000,
      S_DOWN   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            case (stat.plan_op)
               OP_INS:  state_in = S_UP;
               OP_EXT:  state_in = S_DOWN;
               OP_READ: state_in = S_DOWN;
               default: state_in = S_FINISH;
            endcase
         end
         S_UP: begin
            cmd.step_up = 1'b1;
            if (stat.walk_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_FINISH;
         end
         S_DOWN: begin
            cmd.step_down = 1'b1;
            if (stat.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ hdl/bpl_dpath.sv @@
// Datapath of the bounded positional list: request registers, decode,
// element memory with one entry moved per cycle, length counter and result word.
// Depends on bpl_pkg.
module bpl_dpath
   import bpl_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
   parameter int WORD_WIDTH  = DEFAULT_WORD_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [POS_W-1:0]      req_position,
   input  logic [WORD_WIDTH-1:0] req_element_value,
   input  logic [BYTES_W-1:0]    req_element_bytes,
   input  logic [CAP_W-1:0]      capacity,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [WORD_WIDTH-1:0] rsp_result_value,
   output logic [BYTES_W-1:0]    rsp_result_bytes,
   output logic [LEN_W-1:0]      rsp_length,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full
);

   localparam int AddrW  = $clog2(MAX_ENTRIES);
   localparam int CntW   = $clog2(MAX_ENTRIES + 1);
   localparam int CmpW   = (CntW > POS_W) ? CntW : POS_W;
   localparam int EntryW = WORD_WIDTH + BYTES_W;

   logic [EntryW-1:0] entry_mem [MAX_ENTRIES];

   logic [KIND_W-1:0]     kind_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [WORD_WIDTH-1:0] word_ff;
   logic [BYTES_W-1:0]    bytes_ff;
   logic [CntW-1:0]       count_ff, count_in;
   op_type                op_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [AddrW-1:0]      at_ff;
   logic [CntW-1:0]       left_ff;
   logic [AddrW-1:0]      src_ff;
   logic                  pend_ff;
   logic                  pend_take_ff;
   logic [AddrW-1:0]      pend_dst_ff;
   logic [EntryW-1:0]     rd_data_ff;
   logic [EntryW-1:0]     take_ff;

   // Decode of the captured request against the current length.
   logic [CmpW-1:0]     cnt_x, pos_x, cap_x, lim_x;
   logic                full_now, pos_out;
   logic [AddrW-1:0]    last_idx, pos_idx, cnt_idx;
   op_type              plan_op;
   logic [STATUS_W-1:0] plan_status;
   logic [AddrW-1:0]    plan_at;
   logic [CntW-1:0]     plan_left;
   logic [AddrW-1:0]    plan_src;
   logic [CntW-1:0]     last_cnt;

   assign cnt_x    = CmpW'(count_ff);
   assign pos_x    = CmpW'(pos_ff);
   assign cap_x    = CmpW'(capacity);
   assign lim_x    = (cap_x > CmpW'(MAX_ENTRIES)) ? CmpW'(MAX_ENTRIES) : cap_x;
   assign full_now = cnt_x >= lim_x;
   assign pos_out  = pos_x >= cnt_x;
   assign last_cnt = count_ff - CntW'(1);
   assign last_idx = last_cnt[AddrW-1:0];
   assign pos_idx  = pos_x[AddrW-1:0];
   assign cnt_idx  = cnt_x[AddrW-1:0];

   always_comb begin
      plan_op     = OP_NONE;
      plan_status = RSP_OK;
      plan_at     = '0;
      case (kind_ff)
         KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
            if (full_now) begin
               plan_status = RSP_FULL;
            end else begin
               plan_op = OP_INS;
               if (kind_ff == KIND_INS_FIRST) begin
                  plan_at = '0;
               end else if (kind_ff == KIND_INS_LAST || pos_out) begin
                  plan_at = cnt_idx;
               end else begin
                  plan_at = pos_idx;
               end
            end
         end
         KIND_EXT_FIRST, KIND_EXT_LAST, KIND_EXT_AT: begin
            if (count_ff == '0) begin
               plan_status = RSP_EMPTY;
            end else if (kind_ff == KIND_EXT_FIRST) begin
               plan_op = OP_EXT;
               plan_at = '0;
            end else if (kind_ff == KIND_EXT_LAST) begin
               plan_op = OP_EXT;
               plan_at = last_idx;
            end else if (pos_out) begin
               plan_status = RSP_RANGE;
            end else begin
               plan_op = OP_EXT;
               plan_at = pos_idx;
            end
         end
         KIND_READ_AT: begin
            if (pos_out) begin
               plan_status = RSP_RANGE;
            end else begin
               plan_op = OP_READ;
               plan_at = pos_idx;
            end
         end
         default: begin
            plan_op     = OP_NONE;
            plan_status = RSP_OK;
         end
      endcase
   end

   // An insert moves entries from the tail down to the insert point one place up;
   // an extract reads the taken entry first, then moves the rest one place down.
   always_comb begin
      plan_left = count_ff - CntW'(plan_at);
      plan_src  = plan_at;
      case (plan_op)
         OP_INS:  plan_src = last_idx;
         OP_READ: plan_left = CntW'(1);
         default: plan_src = plan_at;
      endcase
   end

   assign stat.plan_op   = plan_op;
   assign stat.walk_done = (left_ff == '0) && !pend_ff;

   logic step, walk_wr, mem_we;
   logic [AddrW-1:0]  mem_waddr;
   logic [EntryW-1:0] mem_wdata;

   assign step      = cmd.step_up || cmd.step_down;
   assign walk_wr   = step && pend_ff && !pend_take_ff;
   assign mem_we    = walk_wr || cmd.place;
   assign mem_waddr = cmd.place ? at_ff : pend_dst_ff;
   assign mem_wdata = cmd.place ? {bytes_ff, word_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[src_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         pos_ff   <= req_position;
         word_ff  <= req_element_value;
         bytes_ff <= req_element_bytes;
      end
      if (cmd.decide) begin
         op_ff     <= plan_op;
         status_ff <= plan_status;
         at_ff     <= plan_at;
         src_ff    <= plan_src;
      end else if (step && left_ff != '0) begin
         src_ff       <= cmd.step_up ? src_ff - AddrW'(1) : src_ff + AddrW'(1);
         pend_dst_ff  <= cmd.step_up ? src_ff + AddrW'(1) : src_ff - AddrW'(1);
         pend_take_ff <= cmd.step_down && (src_ff == at_ff);
      end
      if (cmd.step_down && pend_ff && pend_take_ff) begin
         take_ff <= rd_data_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.finish) begin
         case (op_ff)
            OP_INS:  count_in = count_ff + CntW'(1);
            OP_EXT:  count_in = count_ff - CntW'(1);
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.decide) begin
            left_ff <= (plan_op == OP_NONE) ? '0 : plan_left;
            pend_ff <= 1'b0;
         end else if (step) begin
            pend_ff <= (left_ff != '0);
            if (left_ff != '0) begin
               left_ff <= left_ff - CntW'(1);
            end
         end
      end
   end

   logic            has_payload;
   logic [CmpW-1:0] new_len;

   assign has_payload = (op_ff == OP_EXT) || (op_ff == OP_READ);
   assign new_len     = CmpW'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status       <= status_ff;
         rsp_result_value <= has_payload ? take_ff[WORD_WIDTH-1:0] : '0;
         rsp_result_bytes <= has_payload ? take_ff[EntryW-1:WORD_WIDTH] : '0;
         rsp_length       <= new_len[LEN_W-1:0];
         rsp_is_empty     <= (new_len == '0);
         rsp_is_full      <= (new_len >= lim_x);
      end
   end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for bounded_positional_list: stream requests, stream results
// and capacity writes over APB, checked against an in-bench list predictor.
// Depends on bpl_pkg and the bounded_positional_list RTL only.
module testbench;
   import bpl_pkg::*;

   localparam int REQ_W          = 48;
   localparam int RSP_W          = 48;
   localparam int SLOTS          = DEFAULT_MAX_ENTRIES;
   localparam int SETTLE_CYCLES  = DEFAULT_MAX_ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 172;

   // The kind code that the block has no meaning for.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [31:0]         value;
      logic [BYTES_W-1:0]  bytes;
      logic [LEN_W-1:0]    length;
      logic                empty;
      logic                full;
   } list_result_type;

   class list_scoreboard;
      logic [31:0]        words [SLOTS];
      logic [BYTES_W-1:0] sizes [SLOTS];
      int unsigned        held;
      logic [CAP_W-1:0]   capacity;
      list_result_type    awaited [$];
      int                 mismatches;
      int                 kinds_seen [8];
      int                 status_seen [4];
      int                 peak_length;

      function new();
         held = 0;
         capacity = CAP_RESET;
         mismatches = 0;
         peak_length = 0;
         foreach (kinds_seen[i]) kinds_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int unsigned room();
         return (capacity > SLOTS) ? SLOTS : capacity;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_failure(string what);
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR at %0t: %s", $time, what);
      endfunction

      // Applies one accepted request to the list copy and queues the result it must give.
      function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                 logic [31:0] value, logic [BYTES_W-1:0] bytes);
         list_result_type outcome;
         int unsigned     at;
         logic            was_full;
         outcome = '0;
         outcome.status = RSP_OK;
         was_full = (held >= room());
         kinds_seen[kind]++;
         case (kind)
            KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
               if (was_full) begin
                  outcome.status = RSP_FULL;
               end else begin
                  if (kind == KIND_INS_FIRST)
                     at = 0;
                  else if (kind == KIND_INS_LAST || pos >= held)
                     at = held;
                  else
                     at = pos;
                  for (int i = held; i > at; i--) begin
                     words[i] = words[i-1];
                     sizes[i] = sizes[i-1];
                  end
                  words[at] = value;
                  sizes[at] = bytes;
                  held++;
               end
            end
            KIND_EXT_FIRST, KIND_EXT_LAST, KIND_EXT_AT: begin
               if (held == 0) begin
                  outcome.status = RSP_EMPTY;
               end else if (kind == KIND_EXT_AT && pos >= held) begin
                  outcome.status = RSP_RANGE;
               end else begin
                  if (kind == KIND_EXT_FIRST)
                     at = 0;
                  else if (kind == KIND_EXT_LAST)
                     at = held - 1;
                  else
                     at = pos;
                  outcome.value = words[at];
                  outcome.bytes = sizes[at];
                  for (int i = at; i + 1 < held; i++) begin
                     words[i] = words[i+1];
                     sizes[i] = sizes[i+1];
                  end
                  held--;
               end
            end
            KIND_READ_AT: begin
               if (pos >= held) begin
                  outcome.status = RSP_RANGE;
               end else begin
                  outcome.value = words[pos];
                  outcome.bytes = sizes[pos];
               end
            end
            default: ;
         endcase
         outcome.length = held[LEN_W-1:0];
         outcome.empty = (held == 0);
         outcome.full = (held >= room());
         if (held > peak_length) peak_length = held;
         awaited.push_back(outcome);
      endfunction

      function void check_result(list_result_type got);
         list_result_type want;
         if (awaited.size() == 0) begin
            note_failure($sformatf("result with nothing outstanding: status %0d value %h",
                                   got.status, got.value));
            return;
         end
         want = awaited.pop_front();
         status_seen[want.status]++;
         if (got.status !== want.status || got.value !== want.value ||
             got.bytes !== want.bytes || got.length !== want.length ||
             got.empty !== want.empty || got.full !== want.full)
            note_failure($sformatf({"expected status %0d value %h bytes %0d length %0d ",
                                    "empty %0b full %0b, got status %0d value %h bytes %0d ",
                                    "length %0d empty %0b full %0b"},
                                   want.status, want.value, want.bytes, want.length,
                                   want.empty, want.full, got.status, got.value, got.bytes,
                                   got.length, got.empty, got.full));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]  req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   list_scoreboard     sb;
   int                 burst_left = 0;
   bit                 valid_held = 0;
   bit                 filling = 1;
   int                 caps_written = 0;
   int                 idle_cycles = 0;
   int                 stall_count = 0;
   int                 stall_mode = 0;

   bounded_positional_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Request word layout: position [6:0], element_value [38:7], element_bytes [41:39].
   // Result word layout: result_value [31:0], result_bytes [34:32], length [41:35],
   // is_empty [42], is_full [43].
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[6:0], req_tdata[38:7], req_tdata[41:39]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result({rsp_tuser, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[41:35],
                             rsp_tdata[42], rsp_tdata[43]});
      end
   end

   // The result side cycles through its own stall patterns, including long stretches
   // of always-ready.
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 150 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_count % 4 == 0);
         default: rsp_tready <= (stall_count % 16 >= 12);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_positional_list test failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [31:0] value, input logic [BYTES_W-1:0] bytes);
      int gap;
      req_tvalid <= 1'b1;
      valid_held = 1;
      req_tuser <= kind;
      req_tdata <= {6'd0, bytes, value, pos};
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            valid_held = 0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      if (valid_held) begin
         req_tvalid <= 1'b0;
         valid_held = 0;
      end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_CAPACITY_ADDR;
      csr_pwdata <= {25'd0, cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_capacity(cap);
      caps_written++;
      // Follow straight on with a read of the same register.
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {25'd0, cap})
         sb.note_failure($sformatf("capacity read back %h, wrote %0d", readback, cap));
   endtask

   task automatic send_random();
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   pos;
      logic [31:0]        value;
      logic [BYTES_W-1:0] bytes;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 2)
         kind = KIND_UNUSED;
      else if (filling)
         kind = (pick < 65) ? KIND_W'($urandom_range(KIND_INS_FIRST, KIND_INS_AT)) :
                (pick < 85) ? KIND_W'($urandom_range(KIND_EXT_FIRST, KIND_EXT_AT)) :
                KIND_READ_AT;
      else
         kind = (pick < 25) ? KIND_W'($urandom_range(KIND_INS_FIRST, KIND_INS_AT)) :
                (pick < 80) ? KIND_W'($urandom_range(KIND_EXT_FIRST, KIND_EXT_AT)) :
                KIND_READ_AT;
      case ($urandom_range(0, 9))
         7: pos = '0;
         8: pos = POS_W'($urandom_range(0, 127));
         9: pos = ($urandom_range(0, 1) != 0) ? 7'd127 : sb.held[POS_W-1:0];
         default: pos = POS_W'($urandom_range(0, sb.held));
      endcase
      case ($urandom_range(0, 9))
         0: value = 32'h0;
         1: value = 32'hFFFF_FFFF;
         default: value = $urandom;
      endcase
      bytes = ($urandom_range(0, 9) == 0) ? BYTES_W'($urandom_range(0, 7)) :
                                            BYTES_W'($urandom_range(1, 4));
      send_request(kind, pos, value, bytes);
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int items);
      int window;
      write_capacity(cap);
      window = 0;
      for (int n = 0; n < items; n++) begin
         if (window == 0) begin
            filling = !filling;
            window = $urandom_range(10, 90);
         end
         window--;
         send_random();
      end
      wait_idle();
   endtask

   initial begin
      logic [CAP_W-1:0] caps [10];
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: every extract reports empty, a read reports out of range.
      send_request(KIND_READ_AT, 7'd0, 32'h0, 3'd1);
      send_request(KIND_EXT_FIRST, 7'd0, 32'h0, 3'd1);
      send_request(KIND_EXT_LAST, 7'd0, 32'h0, 3'd1);
      send_request(KIND_EXT_AT, 7'd0, 32'h0, 3'd1);
      // Inserts at and beyond the length, at the front, and with odd byte counts.
      send_request(KIND_INS_AT, 7'd5, 32'hFFFF_FFFF, 3'd4);
      send_request(KIND_INS_FIRST, 7'd127, 32'h0, 3'd1);
      send_request(KIND_INS_LAST, 7'd0, 32'hA5A5_A5A5, 3'd7);
      send_request(KIND_INS_AT, 7'd0, 32'h1234_5678, 3'd0);
      send_request(KIND_INS_AT, 7'd127, 32'h8000_0001, 3'd2);
      send_request(KIND_INS_AT, 7'd1, 32'h0000_007E, 3'd3);
      send_request(KIND_READ_AT, 7'd0, 32'h0, 3'd0);
      send_request(KIND_READ_AT, 7'd127, 32'h0, 3'd0);
      send_request(KIND_READ_AT, 7'd5, 32'h0, 3'd0);
      send_request(KIND_EXT_AT, 7'd2, 32'h0, 3'd0);
      send_request(KIND_EXT_AT, 7'd127, 32'h0, 3'd0);
      send_request(KIND_UNUSED, 7'd127, 32'hFFFF_FFFF, 3'd7);
      send_request(KIND_EXT_FIRST, 7'd0, 32'h0, 3'd0);
      send_request(KIND_EXT_LAST, 7'd0, 32'h0, 3'd0);
      wait_idle();

      // Capacity dropped below the current length: inserts are refused.
      write_capacity(7'd2);
      send_request(KIND_INS_LAST, 7'd0, 32'hDEAD_BEEF, 3'd4);
      send_request(KIND_READ_AT, 7'd2, 32'h0, 3'd0);
      send_request(KIND_EXT_AT, 7'd1, 32'h0, 3'd0);
      wait_idle();
      write_capacity(7'd0);
      send_request(KIND_INS_FIRST, 7'd0, 32'h0000_0001, 3'd1);
      send_request(KIND_EXT_FIRST, 7'd0, 32'h0, 3'd0);
      send_request(KIND_INS_AT, 7'd0, 32'h0000_0002, 3'd2);
      wait_idle();

      caps = '{7'd64, 7'd1, 7'd127, 7'd17, 7'd0, 7'd64, 7'd2, 7'd40, 7'd64, 7'd64};
      caps[7] = CAP_W'($urandom_range(1, 64));
      foreach (caps[i])
         run_phase(caps[i], PHASE_ITEMS);

      $display({"Ran %0d inserts, %0d extracts, %0d reads, %0d unused-kind requests ",
                "over %0d capacity settings."},
               sb.kinds_seen[0] + sb.kinds_seen[1] + sb.kinds_seen[2],
               sb.kinds_seen[3] + sb.kinds_seen[4] + sb.kinds_seen[5],
               sb.kinds_seen[6], sb.kinds_seen[7], caps_written + 1);
      $display({"Results: %0d ok, %0d full, %0d empty, %0d out of range; ",
                "longest list %0d; %0d errors."},
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
               sb.peak_length, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("bounded_positional_list test passed");
      else
         $display("bounded_positional_list test failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/bpl_pkg.sv
hdl/bpl_ctrl.sv
hdl/bpl_dpath.sv
hdl/bounded_positional_list.sv
test/testbench.sv
